// ----- rtl/kwm_pkg.sv -----
// Shared constants, state encoding and control structs of the k-way merge.
package kwm_pkg;

    localparam int NUM_LISTS   = 8;
    localparam int STORE_DEPTH = 64;

    localparam int VALUE_W   = 16;
    localparam int INDEX_W   = 3;
    localparam int LIST_W    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int ADDR_W    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(STORE_DEPTH + 1);
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PICK,
        ST_LINK,
        ST_VAL
    } state_t;

    typedef struct packed {
        logic append;
        logic pick;
        logic link;
        logic value;
        logic emit_empty;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic fill_zero;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/kwm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module kwm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/kwm_datapath.sv -----
// Datapath of the k-way merge: list store, head registers, minimum select, result register.
module kwm_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  kwm_pkg::cmd_t                  cmd,
    input  logic [kwm_pkg::INDEX_W-1:0]    list_index,
    input  logic [kwm_pkg::VALUE_W-1:0]    value,
    input  logic                           m_tready,
    output kwm_pkg::status_t               status,
    output logic                           out_valid,
    output logic [kwm_pkg::VALUE_W-1:0]    value_res,
    output logic [kwm_pkg::INDEX_W-1:0]    source_list,
    output logic                           last,
    output logic                           empty_res,
    output logic                           overflow
);

    import kwm_pkg::*;

    logic [ADDR_W-1:0]         head_ptr_reg [NUM_LISTS];
    logic [ADDR_W-1:0]         tail_ptr_reg [NUM_LISTS];
    logic signed [VALUE_W-1:0] head_val_reg [NUM_LISTS];
    logic [CNT_W-1:0]          count_reg    [NUM_LISTS];
    logic [CNT_W-1:0]          fill_reg;
    logic                      dropped_reg;
    logic [LIST_W-1:0]         best_reg;

    logic                      out_valid_reg;
    logic [VALUE_W-1:0]        out_value_reg;
    logic [INDEX_W-1:0]        out_src_reg;
    logic                      out_last_reg;
    logic                      out_empty_reg;
    logic                      out_ovf_reg;

    logic                      idx_ok;
    logic                      fill_full;
    logic                      app_ok;
    logic [LIST_W-1:0]         li;
    logic [ADDR_W-1:0]         slot;

    logic                      node_vld [2**LIST_W];
    logic signed [VALUE_W-1:0] node_val [2**LIST_W];
    logic [LIST_W-1:0]         node_idx [2**LIST_W];
    logic [LIST_W-1:0]         best;
    logic signed [VALUE_W-1:0] best_val;

    logic                      link_we;
    logic [ADDR_W-1:0]         link_rdata;
    logic [VALUE_W-1:0]        val_rdata;

    assign idx_ok    = 32'(list_index) < NUM_LISTS;
    assign fill_full = fill_reg == CNT_W'(STORE_DEPTH);
    assign li        = LIST_W'(list_index);
    assign app_ok    = cmd.append && idx_ok && !fill_full;
    assign slot      = ADDR_W'(fill_reg);
    assign link_we   = app_ok && (count_reg[li] != '0);

    always_comb
    begin
        for (int i = 0; i < 2**LIST_W; i++)
        begin
            node_vld[i] = 1'b0;
            node_val[i] = '0;
            node_idx[i] = LIST_W'(i);
            if (i < NUM_LISTS)
            begin
                node_vld[i] = count_reg[i] != '0;
                node_val[i] = head_val_reg[i];
            end
        end
        for (int step = 1; step < 2**LIST_W; step = step * 2)
        begin
            for (int i = 0; i < 2**LIST_W; i = i + 2 * step)
            begin
                if (node_vld[i + step] &&
                    (!node_vld[i] || (node_val[i + step] < node_val[i])))
                begin
                    node_vld[i] = 1'b1;
                    node_val[i] = node_val[i + step];
                    node_idx[i] = node_idx[i + step];
                end
            end
        end
        best     = node_idx[0];
        best_val = node_val[0];
    end

    kwm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (app_ok),
        .waddr (slot),
        .wdata (value),
        .raddr (link_rdata),
        .rdata (val_rdata)
    );

    kwm_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (STORE_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (tail_ptr_reg[li]),
        .wdata (slot),
        .raddr (head_ptr_reg[best]),
        .rdata (link_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                count_reg[i] <= '0;
            end
            fill_reg      <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.append)
            begin
                if (app_ok)
                begin
                    count_reg[li] <= count_reg[li] + 1'b1;
                    fill_reg      <= fill_reg + 1'b1;
                end
                else
                begin
                    dropped_reg <= 1'b1;
                end
            end
            if (cmd.pick)
            begin
                count_reg[best] <= count_reg[best] - 1'b1;
                fill_reg        <= fill_reg - 1'b1;
            end
            if (cmd.clear)
            begin
                for (int i = 0; i < NUM_LISTS; i++)
                begin
                    count_reg[i] <= '0;
                end
                fill_reg    <= '0;
                dropped_reg <= 1'b0;
            end
            if (cmd.pick || cmd.emit_empty)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (app_ok)
        begin
            tail_ptr_reg[li] <= slot;
            if (count_reg[li] == '0)
            begin
                head_ptr_reg[li] <= slot;
                head_val_reg[li] <= value;
            end
        end
        if (cmd.pick)
        begin
            best_reg      <= best;
            out_value_reg <= best_val;
            out_src_reg   <= INDEX_W'(best);
            out_last_reg  <= fill_reg == CNT_W'(1);
            out_empty_reg <= 1'b0;
            out_ovf_reg   <= dropped_reg;
        end
        if (cmd.emit_empty)
        begin
            out_value_reg <= '0;
            out_src_reg   <= '0;
            out_last_reg  <= 1'b1;
            out_empty_reg <= 1'b1;
            out_ovf_reg   <= dropped_reg;
        end
        if (cmd.link)
        begin
            head_ptr_reg[best_reg] <= link_rdata;
        end
        if (cmd.value)
        begin
            head_val_reg[best_reg] <= val_rdata;
        end
    end

    assign status.fill_zero = fill_reg == '0;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign out_valid   = out_valid_reg;
    assign value_res   = out_value_reg;
    assign source_list = out_src_reg;
    assign last        = out_last_reg;
    assign empty_res   = out_empty_reg;
    assign overflow    = out_ovf_reg;

endmodule

// ----- rtl/kwm_ctrl.sv -----
// Controller of the k-way merge: load phase and the pick, link, value merge loop.
module kwm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              kind,
    input  kwm_pkg::status_t  status,
    output logic              in_ready,
    output kwm_pkg::cmd_t     cmd
);

    import kwm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && kind)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (status.out_free)
                begin
                    state_next = status.fill_zero ? ST_IDLE : ST_LINK;
                end
            end
            ST_LINK:
            begin
                state_next = ST_VAL;
            end
            ST_VAL:
            begin
                state_next = status.fill_zero ? ST_IDLE : ST_PICK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.append = in_valid && !kind;
            end
            ST_PICK:
            begin
                cmd.emit_empty = status.out_free && status.fill_zero;
                cmd.clear      = status.out_free && status.fill_zero;
                cmd.pick       = status.out_free && !status.fill_zero;
            end
            ST_LINK:
            begin
                cmd.link = 1'b1;
            end
            ST_VAL:
            begin
                cmd.value = 1'b1;
                cmd.clear = status.fill_zero;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/k_way_sorted_merge.sv -----
// Top level of the k-way sorted merge.
// Append items (tuser 0) load up to eight ascending lists into a shared 64-entry store, one
// item per cycle; appends to a full store are dropped and flagged on the results of the run.
// A finish item (tuser 1) starts the merge: each result takes a pick, link and value step
// (select the smallest head, read its link, read the next head value from the store RAMs),
// and the pick waits while the result register is not drained. No input is taken until the
// last result is loaded. A finish with nothing loaded gives a single result flagged empty.
module k_way_sorted_merge (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kwm_pkg::S_TDATA_W-1:0]   s_tdata,   // list_index[2:0], value[18:3]
    input  logic [0:0]                      s_tuser,   // kind[0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kwm_pkg::M_TDATA_W-1:0]   m_tdata,   // value_res[15:0], source_list[18:16]
    output logic                            m_tlast,
    output logic [1:0]                      m_tuser    // empty_res[0], overflow[1]
);

    import kwm_pkg::*;

    cmd_t               cmd;
    status_t            status;
    logic               in_valid;
    logic [VALUE_W-1:0] value_res;
    logic [INDEX_W-1:0] source_list;

    assign in_valid = s_tvalid;

    kwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (s_tuser[0]),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    kwm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .list_index  (s_tdata[INDEX_W-1:0]),
        .value       (s_tdata[INDEX_W+VALUE_W-1:INDEX_W]),
        .m_tready    (m_tready),
        .status      (status),
        .out_valid   (m_tvalid),
        .value_res   (value_res),
        .source_list (source_list),
        .last        (m_tlast),
        .empty_res   (m_tuser[0]),
        .overflow    (m_tuser[1])
    );

    assign m_tdata = {(M_TDATA_W - VALUE_W - INDEX_W)'(0), source_list, value_res};

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("empty result without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser[0] |=> !$rose(m_tvalid))
        else $error("result raised after an append");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick |=> cmd.link ##1 cmd.value)
        else $error("merge step sequence broken");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick |-> !status.fill_zero && status.out_free)
        else $error("pick without pending element or free result register");

endmodule

// ----- verif/tb.sv -----
// Testbench for k_way_sorted_merge: random list loads checked against a merge predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kwm_pkg::*;

    localparam int  CLK_PERIOD   = 20;
    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  RANDOM_ITEMS = 410;
    localparam int  DRAIN_CYCLES = 16;
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        src;
        logic                      last;
        logic                      empty;
        logic                      ovf;
    } merged_t;

    class merge_predictor;
        logic signed [VALUE_W-1:0] lists[NUM_LISTS][$];
        int                        fill;
        logic                      dropped;
        merged_t                   merged_q[$];
        int                        fail_count;

        function new();
            fill       = 0;
            dropped    = 1'b0;
            fail_count = 0;
        endfunction

        function void take_item(logic kind, logic [INDEX_W-1:0] li,
                                logic signed [VALUE_W-1:0] v);
            int      best;
            int      remaining;
            merged_t r;
            if (kind == KIND_APPEND) begin
                if (int'(li) >= NUM_LISTS || fill >= STORE_DEPTH)
                    dropped = 1'b1;
                else
                begin
                    lists[li].push_back(v);
                    fill++;
                end
                return;
            end
            if (fill == 0) begin
                r.value = '0;
                r.src   = '0;
                r.last  = 1'b1;
                r.empty = 1'b1;
                r.ovf   = dropped;
                merged_q.push_back(r);
            end
            else
            begin
                remaining = fill;
                while (remaining > 0) begin
                    best = -1;
                    for (int i = 0; i < NUM_LISTS; i++) begin
                        if (lists[i].size() != 0 &&
                            (best < 0 || lists[i][0] < lists[best][0]))
                            best = i;
                    end
                    remaining--;
                    r.value = lists[best].pop_front();
                    r.src   = INDEX_W'(best);
                    r.last  = (remaining == 0);
                    r.empty = 1'b0;
                    r.ovf   = dropped;
                    merged_q.push_back(r);
                end
            end
            fill    = 0;
            dropped = 1'b0;
        endfunction

        function void check_merged(logic signed [VALUE_W-1:0] value, logic [INDEX_W-1:0] src,
                                   logic last, logic empty, logic ovf);
            merged_t exp;
            if (merged_q.size() == 0) begin
                $error("result with nothing pending: value_res %0d source_list %0d",
                       value, src);
                fail_count++;
                return;
            end
            exp = merged_q.pop_front();
            if (exp.value !== value) begin
                $error("value_res: expected %0d, got %0d", $signed(exp.value), value);
                fail_count++;
            end
            if (exp.src !== src) begin
                $error("source_list: expected %0d, got %0d", exp.src, src);
                fail_count++;
            end
            if (exp.last !== last) begin
                $error("last: expected %0d, got %0d", exp.last, last);
                fail_count++;
            end
            if (exp.empty !== empty) begin
                $error("empty_res: expected %0d, got %0d", exp.empty, empty);
                fail_count++;
            end
            if (exp.ovf !== ovf) begin
                $error("overflow: expected %0d, got %0d", exp.ovf, ovf);
                fail_count++;
            end
        endfunction
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic [1:0]           m_tuser;

    merge_predictor sb = new();
    int             send_idle_pct = 31;
    int             recv_idle_pct = 61;
    int             items_sent    = 0;
    int             cycle_count   = 0;

    k_way_sorted_merge u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // sample results, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_merged(m_tdata[VALUE_W-1:0], m_tdata[VALUE_W+INDEX_W-1:VALUE_W],
                            m_tlast, m_tuser[0], m_tuser[1]);
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(input logic kind, input logic [INDEX_W-1:0] li,
                             input logic signed [VALUE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W - VALUE_W - INDEX_W){1'b0}}, v, li};
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_item(kind, li, v);
        items_sent++;
    endtask

    task automatic append(input int li, input int v);
        send_item(KIND_APPEND, INDEX_W'(li), VALUE_W'(v));
    endtask

    task automatic finish_run();
        send_item(KIND_FINISH, INDEX_W'($urandom), VALUE_W'($urandom));
    endtask

    task automatic random_run();
        int mode;
        int n;
        int li;
        int v;
        int heads[NUM_LISTS];
        mode = $urandom_range(9);
        if (mode == 0)
            n = $urandom_range(72, 60);
        else if (mode == 1)
            n = 0;
        else
            n = $urandom_range(14, 1);
        for (int i = 0; i < NUM_LISTS; i++)
            heads[i] = int'($urandom_range(65535)) - 32768;
        for (int k = 0; k < n; k++) begin
            li = $urandom_range(NUM_LISTS - 1);
            if ($urandom_range(15) == 0) begin
                v = int'($urandom_range(65535)) - 32768;
            end
            else
            begin
                // advance the list head, keep it in range, allow ties
                if ($urandom_range(3) != 0)
                    heads[li] += $urandom_range(3000);
                if (heads[li] > 32767)
                    heads[li] = 32767;
                v = heads[li];
            end
            append(li, v);
        end
        finish_run();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        finish_run();

        append(0, -32768);
        append(0, 0);
        append(0, 32767);
        append(1, -32768);
        append(2, -1);
        append(2, 5);
        append(3, 100);
        append(3, -100);
        append(4, 0);
        append(5, 32767);
        append(6, 1);
        append(7, -2);
        append(7, 32767);
        finish_run();

        append(7, 21845);
        finish_run();
        append(6, -21846);
        finish_run();

        begin
            int random_end;
            random_end = items_sent + RANDOM_ITEMS;
            while (items_sent < random_end) begin
                if (items_sent < random_end - (2 * RANDOM_ITEMS) / 3) begin
                    send_idle_pct = 31;
                    recv_idle_pct = 61;
                end
                else if (items_sent < random_end - RANDOM_ITEMS / 3) begin
                    send_idle_pct = 61;
                    recv_idle_pct = 31;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                random_run();
            end
        end
        s_tvalid <= 1'b0;

        while (sb.merged_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- k_way_sorted_merge.f -----
rtl/kwm_pkg.sv
rtl/kwm_ram.sv
rtl/kwm_datapath.sv
rtl/kwm_ctrl.sv
rtl/k_way_sorted_merge.sv
verif/tb.sv
